[sv/sapd_pkg.sv]
`default_nettype none

package sapd_pkg;

	localparam int ANGLE_W  = 24;
	localparam int BOUND_W  = 23;
	localparam int GAIN_W   = 16;
	localparam int DIFF_W   = ANGLE_W + 1;
	localparam int PROD_W   = GAIN_W + 1 + DIFF_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int RND_W    = ACC_W - 8;
	localparam int CFG_W    = 24;
	localparam int IDX_W    = 3;

	// 0.30 degree and 8.0 in Q16.8
	localparam logic signed [ANGLE_W-1:0] ANGLE_DEADBAND  = 24'sd77;
	localparam logic [BOUND_W-1:0]        OUTPUT_DEADBAND = 23'd2048;
	localparam logic signed [ANGLE_W-1:0] MAX24 = 24'sh7FFFFF;
	localparam logic signed [ANGLE_W-1:0] MIN24 = 24'sh800000;

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_D         = 3'd2,
		REG_INTEGRAL_BOUND = 3'd3,
		REG_OUTPUT_BOUND   = 3'd4,
		REG_ANGLE_MIN      = 3'd5,
		REG_ANGLE_MAX      = 3'd6,
		REG_DRIVE_OFFSET   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]         gain_p;
		logic [GAIN_W-1:0]         gain_i;
		logic [GAIN_W-1:0]         gain_d;
		logic [BOUND_W-1:0]        integral_bound;
		logic [BOUND_W-1:0]        output_bound;
		logic signed [ANGLE_W-1:0] angle_min;
		logic signed [ANGLE_W-1:0] angle_max;
		logic [BOUND_W-1:0]        drive_offset;
	} cfg_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] measured_angle;
		logic signed [ANGLE_W-1:0] target_angle;
		logic                      enable;
	} in_item_t;

	typedef struct packed {
		logic                      run;
		logic                      at_target;
		logic signed [ANGLE_W-1:0] err;
		logic signed [ANGLE_W-1:0] sum;
		logic signed [DIFF_W-1:0]  diff;
	} err_item_t;

	typedef struct packed {
		logic                     run;
		logic                     at_target;
		logic signed [PROD_W-1:0] prod_p;
		logic signed [PROD_W-1:0] prod_i;
		logic signed [PROD_W-1:0] prod_d;
	} prod_item_t;

endpackage

`default_nettype wire

[sv/sapd_err.sv]
`default_nettype none

module sapd_err
	import sapd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire in_item_t  item,
	input  wire logic      upd,
	output err_item_t      res
);

	logic signed [ANGLE_W-1:0] error_sum_q;
	logic signed [ANGLE_W-1:0] prior_error_q;
	logic signed [ANGLE_W-1:0] tgt;
	logic signed [DIFF_W-1:0]  raw;
	logic signed [ANGLE_W-1:0] err;
	logic signed [DIFF_W-1:0]  sum_raw;
	logic signed [DIFF_W-1:0]  ib;
	logic signed [ANGLE_W-1:0] sum;
	logic                      dead;

	always_comb begin
		// max test wins when the limits cross
		if (item.target_angle > cfg.angle_max) begin
			tgt = cfg.angle_max;
		end else if (item.target_angle < cfg.angle_min) begin
			tgt = cfg.angle_min;
		end else begin
			tgt = item.target_angle;
		end

		raw = DIFF_W'(tgt) - DIFF_W'(item.measured_angle);
		if (raw > DIFF_W'(MAX24)) begin
			err = MAX24;
		end else if (raw < DIFF_W'(MIN24)) begin
			err = MIN24;
		end else begin
			err = raw[ANGLE_W-1:0];
		end

		dead = (err <= ANGLE_DEADBAND) && (err >= -ANGLE_DEADBAND);

		ib      = $signed({2'b00, cfg.integral_bound});
		sum_raw = DIFF_W'(error_sum_q) + DIFF_W'(err);
		if (sum_raw > ib) begin
			sum = ib[ANGLE_W-1:0];
		end else if (sum_raw < -ib) begin
			sum = ANGLE_W'(-ib);
		end else begin
			sum = sum_raw[ANGLE_W-1:0];
		end

		res.run       = item.enable && !dead;
		res.at_target = item.enable && dead;
		res.err       = err;
		res.sum       = sum;
		res.diff      = DIFF_W'(err) - DIFF_W'(prior_error_q);
	end

	// state moves only as an item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q   <= '0;
			prior_error_q <= '0;
		end else if (upd && item.enable) begin
			if (dead) begin
				error_sum_q   <= '0;
				prior_error_q <= '0;
			end else begin
				error_sum_q   <= sum;
				prior_error_q <= err;
			end
		end
	end

endmodule

`default_nettype wire

[sv/sapd_mac.sv]
`default_nettype none

module sapd_mac
	import sapd_pkg::*;
(
	input  wire cfg_t       cfg,
	input  wire err_item_t  item,
	output prod_item_t      res
);

	logic signed [GAIN_W:0] gp;
	logic signed [GAIN_W:0] gi;
	logic signed [GAIN_W:0] gd;

	always_comb begin
		gp = $signed({1'b0, cfg.gain_p});
		gi = $signed({1'b0, cfg.gain_i});
		gd = $signed({1'b0, cfg.gain_d});

		res.run       = item.run;
		res.at_target = item.at_target;
		res.prod_p    = PROD_W'(gp * $signed(DIFF_W'(item.err)));
		res.prod_i    = PROD_W'(gi * $signed(DIFF_W'(item.sum)));
		res.prod_d    = PROD_W'(gd * item.diff);
	end

endmodule

`default_nettype wire

[sv/sapd_out.sv]
`default_nettype none

module sapd_out
	import sapd_pkg::*;
(
	input  wire cfg_t                  cfg,
	input  wire prod_item_t            item,
	output logic signed [ANGLE_W-1:0]  drive,
	output logic                       at_target
);

	logic signed [ACC_W-1:0] acc;
	logic                    neg;
	logic [ACC_W-1:0]        mag;
	logic [ACC_W-1:0]        rnd_sum;
	logic [RND_W-1:0]        rnd;
	logic [BOUND_W-1:0]      om;
	logic [ANGLE_W-1:0]      shifted;

	always_comb begin
		acc = ACC_W'(item.prod_p) + ACC_W'(item.prod_i) + ACC_W'(item.prod_d);
		neg = acc[ACC_W-1];
		mag = neg ? ACC_W'(-acc) : ACC_W'(acc);

		// round half away from zero on the magnitude
		rnd_sum = mag + ACC_W'(128);
		rnd     = rnd_sum[ACC_W-1:8];

		if (rnd > RND_W'(cfg.output_bound)) begin
			om = cfg.output_bound;
		end else begin
			om = rnd[BOUND_W-1:0];
		end

		shifted = ANGLE_W'(om) + ANGLE_W'(cfg.drive_offset);

		if (!item.run || om < OUTPUT_DEADBAND) begin
			drive = '0;
		end else if (!neg) begin
			drive = shifted[ANGLE_W-1] ? MAX24 : $signed(shifted);
		end else begin
			drive = shifted[ANGLE_W-1] ? MIN24 : -$signed(shifted);
		end

		at_target = item.at_target;
	end

endmodule

`default_nettype wire

[sv/steering_angle_pid_deadband.sv]
// Channel | Handshake            | Payload
// --------+----------------------+--------------------------------------------
// in      | in_valid / in_stall  | measured_angle[24] target_angle[24] enable
// out     | out_valid / out_stall| drive[24] at_target
// cfg     | cfg_we               | cfg_index[3] cfg_data[24]
//
// One item per cycle sustained while out_stall is low; an accepted item passes through
// the input register, error stage, product stage and result register.
// The error stage updates the integral and last error as the item leaves the
// input register, so the next item to reach that register already sees them.
// arst_n clears valid bits, controller state and restores register defaults.
// out_stall freezes the result register; bubbles ahead of it still collapse,
// and in_stall rises only once every stage holds an item.

`default_nettype none

module steering_angle_pid_deadband
	import sapd_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,

	input  wire logic                      cfg_we,
	input  wire logic [IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_W-1:0]          cfg_data,

	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [ANGLE_W-1:0] measured_angle,
	input  wire logic signed [ANGLE_W-1:0] target_angle,
	input  wire logic                      enable,

	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [ANGLE_W-1:0]      drive,
	output logic                           at_target
);

	cfg_t       cfg_q;

	logic       v_s1;
	logic       v_s2;
	logic       v_s3;
	logic       v_q;
	in_item_t   item_s1;
	err_item_t  item_s2;
	prod_item_t item_s3;
	err_item_t  err_res;
	prod_item_t mac_res;
	logic signed [ANGLE_W-1:0] drive_nxt;
	logic                      at_target_nxt;
	logic signed [ANGLE_W-1:0] drive_q;
	logic                      at_target_q;

	logic load_out;
	logic load_s3;
	logic load_s2;
	logic load_s1;

	// Configuration: plain register writes, truncated to each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p         <= 16'd957;
			cfg_q.gain_i         <= 16'd703;
			cfg_q.gain_d         <= 16'd330;
			cfg_q.integral_bound <= 23'd8388607;
			cfg_q.output_bound   <= 23'd8388607;
			cfg_q.angle_min      <= MIN24;
			cfg_q.angle_max      <= MAX24;
			cfg_q.drive_offset   <= 23'd7680;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_GAIN_P:         cfg_q.gain_p         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:         cfg_q.gain_i         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:         cfg_q.gain_d         <= cfg_data[GAIN_W-1:0];
				REG_INTEGRAL_BOUND: cfg_q.integral_bound <= cfg_data[BOUND_W-1:0];
				REG_OUTPUT_BOUND:   cfg_q.output_bound   <= cfg_data[BOUND_W-1:0];
				REG_ANGLE_MIN:      cfg_q.angle_min      <= $signed(cfg_data);
				REG_ANGLE_MAX:      cfg_q.angle_max      <= $signed(cfg_data);
				REG_DRIVE_OFFSET:   cfg_q.drive_offset   <= cfg_data[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	// Each stage loads when it is empty or its item moves on this cycle.
	assign load_out = !v_q || !out_stall;
	assign load_s3  = !v_s3 || load_out;
	assign load_s2  = !v_s2 || load_s3;
	assign load_s1  = !v_s1 || load_s2;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= in_valid;
			end
			if (load_s2) begin
				v_s2 <= v_s1;
			end
			if (load_s3) begin
				v_s3 <= v_s2;
			end
			if (load_out) begin
				v_q <= v_s3;
			end
		end
	end

	// Payload registers: advance with their valid bits, no reset needed.
	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			item_s1.measured_angle <= measured_angle;
			item_s1.target_angle   <= target_angle;
			item_s1.enable         <= enable;
		end
		if (load_s2 && v_s1) begin
			item_s2 <= err_res;
		end
		if (load_s3 && v_s2) begin
			item_s3 <= mac_res;
		end
		if (load_out && v_s3) begin
			drive_q     <= drive_nxt;
			at_target_q <= at_target_nxt;
		end
	end

	// Error, deadband test and integral; owns the controller state.
	sapd_err u_err (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_s1),
		.upd    (v_s1 && load_s2),
		.res    (err_res)
	);

	// Three gain products in parallel.
	sapd_mac u_mac (
		.cfg  (cfg_q),
		.item (item_s2),
		.res  (mac_res)
	);

	// Sum, round, clamp, output deadband, offset and saturate.
	sapd_out u_out (
		.cfg       (cfg_q),
		.item      (item_s3),
		.drive     (drive_nxt),
		.at_target (at_target_nxt)
	);

	assign out_valid = v_q;
	assign drive     = drive_q;
	assign at_target = at_target_q;

endmodule

`default_nettype wire

[sv/sapd_checker.sv]
`default_nettype none

module sapd_checker
	import sapd_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_stall,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic signed [ANGLE_W-1:0] drive,
	input wire logic                      at_target
);

	// an item at target never carries drive
	a_target_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_target |-> drive == '0)
		else $error("drive nonzero on an at_target item");

	// nonzero drive always clears the output deadband
	a_drive_deadband: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive != '0 |-> drive >= 24'sd2048 || drive <= -24'sd2048)
		else $error("drive inside output deadband");

	// input is held back only when the whole pipe is full and blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive) && $stable(at_target))
		else $error("stalled result changed");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> !$past(out_stall))
		else $error("result dropped while stalled");

endmodule

bind steering_angle_pid_deadband sapd_checker u_sapd_checker (.*);

`default_nettype wire

[sim/testbench.sv]
module testbench;
	import sapd_pkg::*;

	// Watchdog limit on cycles in which no item moves on either channel.
	localparam int QUIET_LIMIT = 3000;
	// Long receiver hold-off, long enough to fill every stage of the pipe.
	localparam int LONG_HOLD = 80;
	// Cycles to let the pipe go quiet before touching the registers.
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_PER_SETTING = 105;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] drive;
		logic                      at_target;
	} drive_result_t;

	typedef enum int {
		SET_FLOOR,
		SET_CEILING,
		SET_SWAPPED,
		SET_TIGHT,
		SET_RANDOM
	} setting_t;

	// Steering PID predictor plus the queue of drive results still owed by the block.
	class pid_tracker;
		cfg_t                      regs;
		logic signed [ANGLE_W-1:0] error_sum;
		logic signed [ANGLE_W-1:0] prev_err;
		drive_result_t             drives_due[$];
		int unsigned               samples, idle_samples, settled, pushed, checked, mismatches;

		function new();
			regs.gain_p         = 16'd957;
			regs.gain_i         = 16'd703;
			regs.gain_d         = 16'd330;
			regs.integral_bound = 23'd8388607;
			regs.output_bound   = 23'd8388607;
			regs.angle_min      = MIN24;
			regs.angle_max      = MAX24;
			regs.drive_offset   = 23'd7680;
			error_sum = '0;
			prev_err  = '0;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_GAIN_P:         regs.gain_p         = data[GAIN_W-1:0];
				REG_GAIN_I:         regs.gain_i         = data[GAIN_W-1:0];
				REG_GAIN_D:         regs.gain_d         = data[GAIN_W-1:0];
				REG_INTEGRAL_BOUND: regs.integral_bound = data[BOUND_W-1:0];
				REG_OUTPUT_BOUND:   regs.output_bound   = data[BOUND_W-1:0];
				REG_ANGLE_MIN:      regs.angle_min      = data;
				REG_ANGLE_MAX:      regs.angle_max      = data;
				REG_DRIVE_OFFSET:   regs.drive_offset   = data[BOUND_W-1:0];
				default: ;
			endcase
		endfunction

		function void accept_sample(logic signed [ANGLE_W-1:0] meas,
				logic signed [ANGLE_W-1:0] tgt, logic en);
			drive_result_t due;
			longint aim, amin, amax, err, mag, acc_err, acc, pid;
			longint gp, gi, gd, ib, ob, off;
			due.drive     = '0;
			due.at_target = 1'b0;
			samples++;
			if (!en) begin
				idle_samples++;
			end else begin
				amin = $signed(regs.angle_min);
				amax = $signed(regs.angle_max);
				aim  = tgt;
				// upper limit wins when the limits cross
				if (aim > amax)
					aim = amax;
				else if (aim < amin)
					aim = amin;
				err = clamp(aim - longint'(meas), MIN24, MAX24);
				mag = (err < 0) ? -err : err;
				if (mag <= ANGLE_DEADBAND) begin
					error_sum     = '0;
					prev_err      = '0;
					due.at_target = 1'b1;
					settled++;
				end else begin
					gp  = regs.gain_p;
					gi  = regs.gain_i;
					gd  = regs.gain_d;
					ib  = regs.integral_bound;
					ob  = regs.output_bound;
					off = regs.drive_offset;
					acc_err = clamp(longint'(error_sum) + err, -ib, ib);
					acc = gp * err + gi * acc_err + gd * (err - longint'(prev_err));
					pid = (acc >= 0) ? ((acc + 128) >>> 8) : -((128 - acc) >>> 8);
					pid = clamp(pid, -ob, ob);
					mag = (pid < 0) ? -pid : pid;
					if (mag < longint'(OUTPUT_DEADBAND))
						pid = 0;
					else if (pid > 0)
						pid = pid + off;
					else
						pid = pid - off;
					pid = clamp(pid, MIN24, MAX24);
					due.drive = pid[ANGLE_W-1:0];
					error_sum = acc_err[ANGLE_W-1:0];
					prev_err  = err[ANGLE_W-1:0];
					if (pid != 0)
						pushed++;
				end
			end
			drives_due.push_back(due);
		endfunction

		function void check_drive(logic signed [ANGLE_W-1:0] drv, logic at_tgt);
			drive_result_t due;
			if (drives_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result drive=%0d at_target=%0b", drv, at_tgt);
				return;
			end
			due = drives_due.pop_front();
			checked++;
			if (drv !== due.drive || at_tgt !== due.at_target) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d: drive exp %0d got %0d, at_target exp %0b got %0b",
						checked, due.drive, drv, due.at_target, at_tgt);
			end
		endfunction

		function void flush_check();
			if (drives_due.size() != 0) begin
				mismatches++;
				$display("ERROR: %0d results never arrived", drives_due.size());
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [IDX_W-1:0]          cfg_index = '0;
	logic [CFG_W-1:0]          cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic signed [ANGLE_W-1:0] measured_angle = '0;
	logic signed [ANGLE_W-1:0] target_angle = '0;
	logic                      enable = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [ANGLE_W-1:0] drive;
	logic                      at_target;

	pid_tracker sb;
	bit         hold_request;
	int         quiet_cycles;
	int         burst_left;
	int         track_left;
	longint     track_target, track_pos;
	int         settings_used;

	setting_t plan [7] = '{SET_FLOOR, SET_CEILING, SET_SWAPPED, SET_TIGHT,
		SET_RANDOM, SET_RANDOM, SET_RANDOM};

	steering_angle_pid_deadband dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.measured_angle (measured_angle),
		.target_angle   (target_angle),
		.enable         (enable),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive          (drive),
		.at_target      (at_target)
	);

	always #5 clk = ~clk;

	// Sample both channels at the edge: note every accepted item, check every
	// accepted result, and count cycles in which nothing moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.accept_sample(measured_angle, target_angle, enable);
			if (out_valid && !out_stall)
				sb.check_drive(drive, at_target);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// Abort when the pipe stops moving for far longer than any legal stall.
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("watchdog: nothing accepted for %0d cycles", QUIET_LIMIT);
		$display("testbench failed");
		$finish;
	end

	// Receiver: stall in segments of random density, including clean stretches;
	// on request, hold off for a long stretch so the block backs up into in_stall.
	initial begin : receiver
		int stall_pct;
		int seg_left;
		int hold_left;
		stall_pct = 0;
		seg_left  = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(8, 64);
					case ($urandom_range(4))
						0, 1:    stall_pct = 0;
						2:       stall_pct = 30;
						3:       stall_pct = 60;
						default: stall_pct = 90;
					endcase
				end
				seg_left--;
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic logic signed [ANGLE_W-1:0] sat24(longint v);
		if (v > MAX24)
			return MAX24;
		if (v < MIN24)
			return MIN24;
		return v[ANGLE_W-1:0];
	endfunction

	// Angles: mostly within a steering range, sometimes anywhere, sometimes an extreme.
	function automatic longint pick_angle();
		logic signed [ANGLE_W-1:0] raw;
		raw = 24'($urandom);
		case ($urandom_range(5))
			0: return raw;
			1: begin
				case ($urandom_range(3))
					0:       return MAX24;
					1:       return MIN24;
					2:       return 0;
					default: return -1;
				endcase
			end
			default: return longint'($urandom_range(46080)) - 23040;
		endcase
	endfunction

	function automatic cfg_t pick_setting(setting_t kind);
		cfg_t   c;
		longint a, b;
		c.gain_p = ($urandom_range(1) != 0) ? 16'($urandom_range(2047)) : 16'($urandom);
		c.gain_i = ($urandom_range(1) != 0) ? 16'($urandom_range(2047)) : 16'($urandom);
		c.gain_d = ($urandom_range(1) != 0) ? 16'($urandom_range(2047)) : 16'($urandom);
		c.integral_bound = ($urandom_range(1) != 0) ? 23'($urandom_range(200000)) : 23'($urandom);
		c.output_bound   = ($urandom_range(1) != 0) ? 23'($urandom_range(200000)) : 23'($urandom);
		c.drive_offset   = ($urandom_range(1) != 0) ? 23'($urandom_range(16384)) : 23'($urandom);
		a = pick_angle();
		b = pick_angle();
		c.angle_min = sat24((a < b) ? a : b);
		c.angle_max = sat24((a < b) ? b : a);
		case (kind)
			SET_FLOOR: begin
				c.gain_p         = '0;
				c.gain_i         = '0;
				c.gain_d         = '0;
				c.integral_bound = '0;
				c.output_bound   = '0;
				c.angle_min      = '0;
				c.angle_max      = '0;
				c.drive_offset   = '0;
			end
			SET_CEILING: begin
				c.gain_p         = '1;
				c.gain_i         = '1;
				c.gain_d         = '1;
				c.integral_bound = '1;
				c.output_bound   = '1;
				c.angle_min      = MIN24;
				c.angle_max      = MAX24;
				c.drive_offset   = '1;
			end
			SET_SWAPPED: begin
				// limits cross: 20 degrees low limit, -20 degrees high limit
				c.angle_min = 24'sd5120;
				c.angle_max = -24'sd5120;
			end
			SET_TIGHT: begin
				c.integral_bound = 23'd1000;
				c.output_bound   = 23'd4000;
				c.angle_min      = -24'sd23040;
				c.angle_max      = 24'sd23040;
			end
			default: ;
		endcase
		return c;
	endfunction

	// Register word; the spare top bit of the 23-bit registers is random to
	// check that it is dropped.
	function automatic logic [CFG_W-1:0] cfg_word(cfg_t c, reg_idx_t r);
		case (r)
			REG_GAIN_P:         return {8'h00, c.gain_p};
			REG_GAIN_I:         return {8'h00, c.gain_i};
			REG_GAIN_D:         return {8'h00, c.gain_d};
			REG_INTEGRAL_BOUND: return {($urandom_range(1) != 0), c.integral_bound};
			REG_OUTPUT_BOUND:   return {($urandom_range(1) != 0), c.output_bound};
			REG_ANGLE_MIN:      return c.angle_min;
			REG_ANGLE_MAX:      return c.angle_max;
			REG_DRIVE_OFFSET:   return {($urandom_range(1) != 0), c.drive_offset};
			default:            return '0;
		endcase
	endfunction

	// Write all eight registers back to back; only call with the pipe empty.
	task automatic load_setting(input cfg_t c);
		reg_idx_t         r;
		logic [CFG_W-1:0] word;
		r = r.first();
		do begin
			word = cfg_word(c, r);
			cfg_we    <= 1'b1;
			cfg_index <= r;
			cfg_data  <= word;
			@(posedge clk);
			sb.write_reg(r, word);
			r = r.next();
		end while (r != r.first());
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Offer one item, opening a new burst after a random gap when the last one ran out.
	task automatic send(input logic signed [ANGLE_W-1:0] meas,
			input logic signed [ANGLE_W-1:0] tgt, input logic en);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			case ($urandom_range(5))
				0, 1:    gap = 0;
				2:       gap = $urandom_range(20, 40);
				default: gap = $urandom_range(1, 8);
			endcase
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid       <= 1'b1;
		measured_angle <= meas;
		target_angle   <= tgt;
		enable         <= en;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Stop offering and hold until every result owed has come back; wait on the
	// clock first so the item accepted at the last edge is already counted.
	task automatic drain();
		in_valid  <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (sb.drives_due.size() != 0);
	endtask

	task automatic run_random(input int count, input int ph);
		longint tgt;
		int     kind;
		for (int k = 0; k < count; k++) begin
			if (k == count / 2) begin
				if (ph % 2 == 1)
					hold_request = 1'b1;
				else if (ph > 0)
					drain();
			end
			kind = $urandom_range(99);
			if (kind < 60) begin
				// tracking run: fixed target, measured angle closing in with noise
				if (track_left == 0) begin
					track_left   = $urandom_range(4, 30);
					track_target = pick_angle();
					track_pos    = pick_angle();
				end
				track_left--;
				track_pos = track_pos + (track_target - track_pos) / 2
					+ longint'($urandom_range(60)) - 30;
				track_pos = sat24(track_pos);
				send(sat24(track_pos), sat24(track_target), $urandom_range(15) != 0);
			end else if (kind < 72) begin
				// straddle the angle deadband
				tgt = pick_angle();
				send(sat24(tgt + longint'($urandom_range(400)) - 200), sat24(tgt), 1'b1);
			end else if (kind < 82) begin
				send(24'($urandom), 24'($urandom), 1'b0);
			end else begin
				send(24'($urandom), 24'($urandom), $urandom_range(1) != 0);
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset settings.
		send(MAX24, MIN24, 1'b0);              // disabled, extreme fields
		send(24'sd0, 24'sd0, 1'b1);            // zero error
		send(24'sd0, 24'sd77, 1'b1);           // deadband edge, both signs
		send(24'sd0, -24'sd77, 1'b1);
		send(24'sd0, 24'sd78, 1'b1);           // just outside: small PID, output deadband
		send(24'sd0, -24'sd78, 1'b1);
		send(MIN24, MAX24, 1'b1);              // error saturates high, integral grows
		send(MIN24, MAX24, 1'b1);
		send(24'sd0, 24'sd0, 1'b0);            // hold state while disabled
		send(MAX24, MIN24, 1'b1);              // error saturates low
		send(MAX24, MIN24, 1'b1);
		send(24'sd0, 24'sd0, 1'b1);            // clear the state again
		send(24'sd1280, 24'sd3840, 1'b1);      // closing on a 15 degree target
		send(24'sd1536, 24'sd3840, 1'b1);
		send(24'sd2304, 24'sd3840, 1'b1);
		send(24'sd3800, 24'sd3840, 1'b1);
		send(-24'sd1, MIN24, 1'b1);
		send(MIN24, MIN24, 1'b1);
		send(MAX24, MAX24, 1'b1);
		send(24'sd600, 24'sd0, 1'b1);
		send(-24'sd1, -24'sd1, 1'b0);
		run_random(RANDOM_PER_SETTING, 0);

		// Step through the register settings, each loaded with the pipe idle.
		foreach (plan[i]) begin
			drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
			load_setting(pick_setting(plan[i]));
			if (plan[i] == SET_SWAPPED) begin
				send(24'sd0, 24'sd10000, 1'b1);    // above the high limit
				send(24'sd0, -24'sd10000, 1'b1);   // below the low limit only
				send(24'sd0, 24'sd0, 1'b1);        // between: high limit still wins
				send(-24'sd5100, 24'sd0, 1'b1);
			end
			run_random(RANDOM_PER_SETTING, i + 1);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.flush_check();

		$display("covered %0d items over %0d register settings, %0d results checked",
			sb.samples, settings_used + 1, sb.checked);
		$display("%0d disabled, %0d at target, %0d nonzero drives, %0d mismatches",
			sb.idle_samples, sb.settled, sb.pushed, sb.mismatches);
		if (sb.mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
